// ===== hw/rtl/sha512_pkg.sv =====
// Package with the shared types, constants and round constants of the SHA-512 engine.
`timescale 1ns / 1ps
package sha512_pkg;
	localparam int unsigned WordW = 64;
	localparam int unsigned Rounds = 80;
	localparam int unsigned BlockWords = 16;

	typedef logic [WordW-1:0] word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		SEL_IN,
		SEL_LAST,
		SEL_MARK,
		SEL_ZERO,
		SEL_LEN
	} push_sel_t;

	typedef struct packed {
		logic push;
		push_sel_t sel;
		logic load;
		logic round;
		logic [6:0] rnd;
		logic final_add;
		logic emit;
		logic [2:0] emit_idx;
		logic init;
	} sha_cmd_t;

	typedef struct packed {
		logic out_free;
	} sha_stat_t;

	function automatic word_t iv(input logic [2:0] i);
		word_t r;
		case (i)
			3'd0: r = 64'h6a09e667f3bcc908;
			3'd1: r = 64'hbb67ae8584caa73b;
			3'd2: r = 64'h3c6ef372fe94f82b;
			3'd3: r = 64'ha54ff53a5f1d36f1;
			3'd4: r = 64'h510e527fade682d1;
			3'd5: r = 64'h9b05688c2b3e6c1f;
			3'd6: r = 64'h1f83d9abfb41bd6b;
			default: r = 64'h5be0cd19137e2179;
		endcase
		return r;
	endfunction

	function automatic word_t round_k(input logic [6:0] t);
		word_t r;
		case (t)
			7'd0: r = 64'h428a2f98d728ae22; 7'd1: r = 64'h7137449123ef65cd;
			7'd2: r = 64'hb5c0fbcfec4d3b2f; 7'd3: r = 64'he9b5dba58189dbbc;
			7'd4: r = 64'h3956c25bf348b538; 7'd5: r = 64'h59f111f1b605d019;
			7'd6: r = 64'h923f82a4af194f9b; 7'd7: r = 64'hab1c5ed5da6d8118;
			7'd8: r = 64'hd807aa98a3030242; 7'd9: r = 64'h12835b0145706fbe;
			7'd10: r = 64'h243185be4ee4b28c; 7'd11: r = 64'h550c7dc3d5ffb4e2;
			7'd12: r = 64'h72be5d74f27b896f; 7'd13: r = 64'h80deb1fe3b1696b1;
			7'd14: r = 64'h9bdc06a725c71235; 7'd15: r = 64'hc19bf174cf692694;
			7'd16: r = 64'he49b69c19ef14ad2; 7'd17: r = 64'hefbe4786384f25e3;
			7'd18: r = 64'h0fc19dc68b8cd5b5; 7'd19: r = 64'h240ca1cc77ac9c65;
			7'd20: r = 64'h2de92c6f592b0275; 7'd21: r = 64'h4a7484aa6ea6e483;
			7'd22: r = 64'h5cb0a9dcbd41fbd4; 7'd23: r = 64'h76f988da831153b5;
			7'd24: r = 64'h983e5152ee66dfab; 7'd25: r = 64'ha831c66d2db43210;
			7'd26: r = 64'hb00327c898fb213f; 7'd27: r = 64'hbf597fc7beef0ee4;
			7'd28: r = 64'hc6e00bf33da88fc2; 7'd29: r = 64'hd5a79147930aa725;
			7'd30: r = 64'h06ca6351e003826f; 7'd31: r = 64'h142929670a0e6e70;
			7'd32: r = 64'h27b70a8546d22ffc; 7'd33: r = 64'h2e1b21385c26c926;
			7'd34: r = 64'h4d2c6dfc5ac42aed; 7'd35: r = 64'h53380d139d95b3df;
			7'd36: r = 64'h650a73548baf63de; 7'd37: r = 64'h766a0abb3c77b2a8;
			7'd38: r = 64'h81c2c92e47edaee6; 7'd39: r = 64'h92722c851482353b;
			7'd40: r = 64'ha2bfe8a14cf10364; 7'd41: r = 64'ha81a664bbc423001;
			7'd42: r = 64'hc24b8b70d0f89791; 7'd43: r = 64'hc76c51a30654be30;
			7'd44: r = 64'hd192e819d6ef5218; 7'd45: r = 64'hd69906245565a910;
			7'd46: r = 64'hf40e35855771202a; 7'd47: r = 64'h106aa07032bbd1b8;
			7'd48: r = 64'h19a4c116b8d2d0c8; 7'd49: r = 64'h1e376c085141ab53;
			7'd50: r = 64'h2748774cdf8eeb99; 7'd51: r = 64'h34b0bcb5e19b48a8;
			7'd52: r = 64'h391c0cb3c5c95a63; 7'd53: r = 64'h4ed8aa4ae3418acb;
			7'd54: r = 64'h5b9cca4f7763e373; 7'd55: r = 64'h682e6ff3d6b2b8a3;
			7'd56: r = 64'h748f82ee5defb2fc; 7'd57: r = 64'h78a5636f43172f60;
			7'd58: r = 64'h84c87814a1f0ab72; 7'd59: r = 64'h8cc702081a6439ec;
			7'd60: r = 64'h90befffa23631e28; 7'd61: r = 64'ha4506cebde82bde9;
			7'd62: r = 64'hbef9a3f7b2c67915; 7'd63: r = 64'hc67178f2e372532b;
			7'd64: r = 64'hca273eceea26619c; 7'd65: r = 64'hd186b8c721c0c207;
			7'd66: r = 64'heada7dd6cde0eb1e; 7'd67: r = 64'hf57d4f7fee6ed178;
			7'd68: r = 64'h06f067aa72176fba; 7'd69: r = 64'h0a637dc5a2c898a6;
			7'd70: r = 64'h113f9804bef90dae; 7'd71: r = 64'h1b710b35131c471b;
			7'd72: r = 64'h28db77f523047d84; 7'd73: r = 64'h32caab7b40c72493;
			7'd74: r = 64'h3c9ebe0a15c9bebc; 7'd75: r = 64'h431d67c49c100d4c;
			7'd76: r = 64'h4cc5d4becb3e42b6; 7'd77: r = 64'h597f299cfc657e2a;
			7'd78: r = 64'h5fcb6fab3ad6faec; 7'd79: r = 64'h6c44198c4a475817;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

// ===== hw/rtl/sha512_ctrl.sv =====
// Controller state machine that sequences absorb, padding, rounds and digest output.
`timescale 1ns / 1ps
module sha512_ctrl
	import sha512_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [3:0] valid_bytes,
	input logic message_end,
	output logic in_stall,
	input sha_stat_t stat,
	output sha_cmd_t cmd
);
	state_t state_q, state_d;
	logic [3:0] widx_q, widx_d;
	logic [6:0] rnd_q, rnd_d;
	logic [2:0] oidx_q, oidx_d;
	logic pad_q, pad_d, mark_q, mark_d, extra_q, extra_d, done_q, done_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			widx_q <= '0;
			rnd_q <= '0;
			oidx_q <= '0;
			pad_q <= 1'b0;
			mark_q <= 1'b0;
			extra_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			widx_q <= widx_d;
			rnd_q <= rnd_d;
			oidx_q <= oidx_d;
			pad_q <= pad_d;
			mark_q <= mark_d;
			extra_q <= extra_d;
			done_q <= done_d;
		end
	end

	always_comb begin
		state_d = state_q;
		widx_d = widx_q;
		rnd_d = rnd_q;
		oidx_d = oidx_q;
		pad_d = pad_q;
		mark_d = mark_q;
		extra_d = extra_q;
		done_d = done_q;
		in_stall = 1'b1;
		cmd = '0;
		cmd.sel = SEL_IN;
		cmd.rnd = rnd_q;
		cmd.emit_idx = oidx_q;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.push = 1'b1;
					if (message_end) begin
						cmd.sel = SEL_LAST;
						pad_d = 1'b1;
						mark_d = (valid_bytes >= 4'd8);
						extra_d = (valid_bytes < 4'd8) && (widx_q == 4'd14);
						state_d = ST_PAD;
					end
					if (widx_q == 4'd15) begin
						cmd.load = 1'b1;
						widx_d = '0;
						rnd_d = '0;
						state_d = ST_ROUND;
					end else begin
						widx_d = widx_q + 4'd1;
					end
				end
			end
			ST_PAD: begin
				cmd.push = 1'b1;
				if (mark_q) begin
					cmd.sel = SEL_MARK;
					mark_d = 1'b0;
					if (widx_q == 4'd14) begin
						extra_d = 1'b1;
					end
				end else if (widx_q == 4'd15 && !extra_q) begin
					cmd.sel = SEL_LEN;
					done_d = 1'b1;
				end else begin
					cmd.sel = SEL_ZERO;
				end
				if (widx_q == 4'd15) begin
					cmd.load = 1'b1;
					extra_d = 1'b0;
					widx_d = '0;
					rnd_d = '0;
					state_d = ST_ROUND;
				end else begin
					widx_d = widx_q + 4'd1;
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				rnd_d = rnd_q + 7'd1;
				if (rnd_q == 7'(Rounds - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.final_add = 1'b1;
				if (done_q) begin
					oidx_d = '0;
					state_d = ST_OUT;
				end else if (pad_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					oidx_d = oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						cmd.init = 1'b1;
						done_d = 1'b0;
						pad_d = 1'b0;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_fin_after_round: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> $past(state_q) == ST_ROUND && $past(rnd_q) == 7'(Rounds - 1))
		else $error("finalize without full round sequence");
	a_out_block_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> widx_q == 4'd0 && done_q)
		else $error("digest output with partial block");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("digest emitted into busy output register");
`endif
endmodule

// ===== hw/rtl/sha512_dp.sv =====
// Datapath with the message schedule, working variables, chaining value and output register.
`timescale 1ns / 1ps
module sha512_dp
	import sha512_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input sha_cmd_t cmd,
	output sha_stat_t stat,
	input word_t message_word,
	input logic [3:0] valid_bytes,
	output logic out_valid,
	input logic out_stall,
	output word_t digest_word,
	output logic digest_last
);
	word_t w_q [BlockWords];
	word_t v_q [8];
	word_t h_q [8];
	word_t total_q;
	word_t dword_q;
	logic dlast_q, ovalid_q;
	logic [3:0] cnt;
	word_t last_w, push_w, w_next, t1, t2, s0, s1, sig0, sig1, ch, maj;
	word_t a, b, c, e, f, g;

	assign cnt = (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
	assign a = v_q[0];
	assign b = v_q[1];
	assign c = v_q[2];
	assign e = v_q[4];
	assign f = v_q[5];
	assign g = v_q[6];

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < cnt) begin
				last_w[63-8*i -: 8] = message_word[63-8*i -: 8];
			end else if (4'(i) == cnt) begin
				last_w[63-8*i -: 8] = 8'h80;
			end else begin
				last_w[63-8*i -: 8] = 8'h00;
			end
		end
		case (cmd.sel)
			SEL_IN: push_w = message_word;
			SEL_LAST: push_w = last_w;
			SEL_MARK: push_w = {8'h80, 56'd0};
			SEL_LEN: push_w = {total_q[60:0], 3'b000};
			default: push_w = '0;
		endcase
		s0 = {w_q[1][0], w_q[1][63:1]} ^ {w_q[1][7:0], w_q[1][63:8]} ^ (w_q[1] >> 7);
		s1 = {w_q[14][18:0], w_q[14][63:19]} ^ {w_q[14][60:0], w_q[14][63:61]}
			^ (w_q[14] >> 6);
		w_next = s1 + w_q[9] + s0 + w_q[0];
		sig1 = {e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]};
		sig0 = {a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]};
		ch = g ^ (e & (f ^ g));
		maj = (a & b) | (c & (a | b));
		t1 = v_q[7] + sig1 + ch + round_k(cmd.rnd) + w_q[0];
		t2 = sig0 + maj;
	end

	always_ff @(posedge clk) begin
		if (cmd.push || cmd.round) begin
			for (int i = 0; i < BlockWords - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[BlockWords-1] <= cmd.push ? push_w : w_next;
		end
		if (cmd.load) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (cmd.round) begin
			v_q[7] <= g;
			v_q[6] <= f;
			v_q[5] <= e;
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= c;
			v_q[2] <= b;
			v_q[1] <= a;
			v_q[0] <= t1 + t2;
		end
		if (cmd.emit) begin
			dword_q <= h_q[cmd.emit_idx];
			dlast_q <= (cmd.emit_idx == 3'd7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= iv(3'(i));
			end
			total_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.init) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= iv(3'(i));
				end
				total_q <= '0;
			end else begin
				if (cmd.final_add) begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
				end
				if (cmd.push && cmd.sel == SEL_IN) begin
					total_q <= total_q + 64'd8;
				end else if (cmd.push && cmd.sel == SEL_LAST) begin
					total_q <= total_q + {60'd0, cnt};
				end
			end
			if (cmd.emit) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign stat.out_free = !ovalid_q || !out_stall;
	assign out_valid = ovalid_q;
	assign digest_word = dword_q;
	assign digest_last = dlast_q;
endmodule

// ===== hw/rtl/sha512_hash_engine.sv =====
// Top level of the SHA-512 hash engine: controller and datapath.
// Input channel: one 64-bit big-endian message word per request, with
// valid_bytes and message_end. Only the last word may be short; counts
// above eight count as eight. Output channel: eight digest words per
// message, H0 first, digest_last on the eighth.
// Words are taken at one per cycle while the engine is idle; the sixteenth
// word of a block starts the compression: 80 rounds at one round per cycle
// in the datapath, then the addition into the chaining value.
// After the last word the engine inserts the padding and length words
// at one per cycle, compresses the final one or two blocks, then moves
// the digest words through a single output register, one per cycle when
// the receiver does not stall. A stall holds the current digest word and
// pauses the engine; no input is taken until all eight words are out.
// Reset loads the initial hash values and clears the byte count; the
// engine is ready for the first word in the cycle after reset ends.
`timescale 1ns / 1ps
module sha512_hash_engine
	import sha512_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [63:0] message_word,
	input logic [3:0] valid_bytes,
	input logic message_end,
	output logic out_valid,
	input logic out_stall,
	output logic [63:0] digest_word,
	output logic digest_last
);
	sha_cmd_t cmd;
	sha_stat_t stat;

	sha512_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.valid_bytes(valid_bytes),
		.message_end(message_end),
		.in_stall(in_stall),
		.stat(stat),
		.cmd(cmd)
	);

	sha512_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.message_word(message_word),
		.valid_bytes(valid_bytes),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.digest_word(digest_word),
		.digest_last(digest_last)
	);
endmodule

// ===== tb/sv/sha512_checker.sv =====
// Checker that predicts SHA-512 digests from observed requests and compares the digest words.
`timescale 1ns / 1ps
module sha512_checker
	import sha512_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic [63:0] message_word,
	input logic [3:0] valid_bytes,
	input logic message_end,
	input logic out_valid,
	input logic out_stall,
	input logic [63:0] digest_word,
	input logic digest_last,
	output int fail_count,
	output int pending_words,
	output int digests_seen
);
	typedef struct {
		logic [63:0] word;
		logic last;
	} digest_t;

	digest_t digest_q[$];
	logic [63:0] chain[8];
	logic [7:0] block_bytes[128];
	logic [63:0] bytes_taken;

	function automatic logic [63:0] ror(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	task automatic start_message();
		for (int i = 0; i < 8; i++) chain[i] = iv(i[2:0]);
		bytes_taken = '0;
	endtask

	task automatic compress();
		logic [63:0] w[80];
		logic [63:0] a, b, c, d, e, f, g, h, t1, t2;
		for (int t = 0; t < 16; t++)
			for (int i = 0; i < 8; i++) w[t] = {w[t][55:0], block_bytes[t * 8 + i]};
		for (int t = 16; t < 80; t++)
			w[t] = w[t-16] + w[t-7]
				+ (ror(w[t-2], 19) ^ ror(w[t-2], 61) ^ (w[t-2] >> 6))
				+ (ror(w[t-15], 1) ^ ror(w[t-15], 8) ^ (w[t-15] >> 7));
		{a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
			chain[4], chain[5], chain[6], chain[7]};
		for (int t = 0; t < 80; t++) begin
			t1 = h + (ror(e, 14) ^ ror(e, 18) ^ ror(e, 41)) + (g ^ (e & (f ^ g)))
				+ round_k(t[6:0]) + w[t];
			t2 = (ror(a, 28) ^ ror(a, 34) ^ ror(a, 39)) + ((a & b) | (c & (a | b)));
			{h, g, f, e, d, c, b, a} = {g, f, e, d + t1, c, b, a, t1 + t2};
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
		chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
	endtask

	task automatic take_byte(input logic [7:0] v);
		block_bytes[bytes_taken[6:0]] = v;
		bytes_taken++;
		if (bytes_taken[6:0] == 0) compress();
	endtask

	task automatic absorb_request(input logic [63:0] wd, input logic [3:0] cnt, input logic fin);
		int n;
		logic [63:0] bits;
		n = (!fin || cnt > 8) ? 8 : cnt;
		for (int i = 0; i < n; i++) take_byte(wd[63 - 8 * i -: 8]);
		if (fin) begin
			bits = bytes_taken << 3;
			take_byte(8'h80);
			while (bytes_taken[6:0] != 7'd112) take_byte(8'h00);
			for (int i = 0; i < 8; i++) take_byte(8'h00);
			for (int i = 0; i < 8; i++) take_byte(bits[63 - 8 * i -: 8]);
			for (int i = 0; i < 8; i++) digest_q.push_back('{chain[i], i == 7});
			start_message();
		end
	endtask

	initial begin
		fail_count = 0;
		digests_seen = 0;
		start_message();
	end

	always @(posedge clk) begin
		digest_t exp_d;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (digest_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected digest word %h last %b", digest_word, digest_last);
				end else begin
					exp_d = digest_q.pop_front();
					if (exp_d.last) digests_seen++;
					if (digest_word !== exp_d.word || digest_last !== exp_d.last) begin
						fail_count++;
						if (fail_count <= 10)
							$display("digest mismatch: expected %h/%b got %h/%b",
								exp_d.word, exp_d.last, digest_word, digest_last);
					end
				end
			end
			if (in_valid && !in_stall) absorb_request(message_word, valid_bytes, message_end);
		end
		pending_words = digest_q.size();
	end
endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the SHA-512 hash engine: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module tb;
	import sha512_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [63:0] message_word = '0;
	logic [3:0] valid_bytes = '0;
	logic message_end = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [63:0] digest_word;
	logic digest_last;
	int fail_count, pending_words, digests_seen;
	int words_sent = 0;
	int stall_mode = 0;

	always #6 clk = ~clk;

	sha512_hash_engine dut (.*);
	sha512_checker chk (.*);

	task automatic send_word(input logic [63:0] wd, input logic [3:0] cnt, input logic fin);
		message_word <= wd;
		valid_bytes <= cnt;
		message_end <= fin;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic idle_gap();
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_message(input int nwords, input logic [3:0] cnt);
		for (int i = 0; i < nwords; i++) begin
			send_word({$urandom, $urandom}, $urandom_range(0, 15), 0);
			idle_gap();
		end
		send_word({$urandom, $urandom}, cnt, 1);
		idle_gap();
	endtask

	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 2) == 0);
			default: out_stall <= ($urandom_range(0, 4) != 0);
		endcase
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int k;
		repeat (9) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		send_word(64'hffff_ffff_ffff_ffff, 4'd0, 1);
		send_word(64'h6162_6300_0000_0000, 4'd3, 1);
		send_word(64'hffff_ffff_ffff_ffff, 4'd15, 1);
		send_word(64'h0, 4'd8, 1);
		send_word(64'hffff_ffff_ffff_ffff, 4'd9, 1);
		send_word(64'h1234_5678_9abc_def0, 4'd7, 1);
		for (int i = 0; i < 13; i++) send_word(64'hffff_ffff_ffff_ffff, 4'd0, 0);
		send_word(64'hdead_beef_0000_0000, 4'd1, 1);
		for (int i = 0; i < 15; i++) send_word(64'h0, 4'd15, 0);
		send_word(64'ha5a5_a5a5_a5a5_a5a5, 4'd8, 1);
		while (words_sent < 272) begin
			k = $urandom_range(0, 9);
			send_message(k < 7 ? $urandom_range(0, 20) : $urandom_range(13, 34),
				$urandom_range(0, 15));
		end
		in_valid <= 0;
		k = 0;
		while (pending_words != 0 && k < 100000) begin
			@(posedge clk);
			k++;
		end
		repeat (50) @(posedge clk);
		$display("%0d words in, %0d digests checked with random sender gaps and output stalls",
			words_sent, digests_seen);
		if (fail_count == 0 && pending_words == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

// ===== files.f =====
hw/rtl/sha512_pkg.sv
hw/rtl/sha512_ctrl.sv
hw/rtl/sha512_dp.sv
hw/rtl/sha512_hash_engine.sv
tb/sv/sha512_checker.sv
tb/sv/tb.sv
